[hw/rtl/blfifo_pkg.sv]
`default_nettype none

package blfifo_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  localparam int HANDLE_W = 32;
  localparam int LEN_W = 16;
  localparam int BYTES_W = 32;
  localparam int ENTRY_W = HANDLE_W + LEN_W;

  localparam logic [BYTES_W-1:0] MIN_RETRY_BYTES = 32'd60;

  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_BURST  = 2'd1,
    OP_DEQ    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Decision for the item held in the execute stage.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               accepted;
    logic               broken_nxt;
    logic [BYTES_W-1:0] bytes_nxt;
  } admit_t;

endpackage

`default_nettype wire

[hw/rtl/blfifo_ram.sv]
`default_nettype none

module blfifo_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/blfifo_admit.sv]
`default_nettype none

module blfifo_admit (
  input  wire logic [1:0]                       op,
  input  wire logic [blfifo_pkg::LEN_W-1:0]     packet_length,
  input  wire logic                             burst_last,
  input  wire logic [blfifo_pkg::BYTES_W-1:0]   capacity,
  input  wire logic [blfifo_pkg::BYTES_W-1:0]   bytes_held,
  input  wire logic [blfifo_pkg::BYTES_W-1:0]   remaining,
  input  wire logic [blfifo_pkg::CNT_W-1:0]     entry_count,
  input  wire logic                             broken,
  input  wire logic [blfifo_pkg::LEN_W-1:0]     head_length,
  output      blfifo_pkg::admit_t               admit
);

  logic                              slot_free;
  logic [blfifo_pkg::BYTES_W:0]      single_sum;
  logic                              single_ok;
  logic                              fits;
  logic                              burst_ok;
  logic [blfifo_pkg::BYTES_W-1:0]    len_ext;
  logic [blfifo_pkg::BYTES_W-1:0]    head_ext;

  assign slot_free  = entry_count < blfifo_pkg::CNT_W'(blfifo_pkg::RING_DEPTH);
  assign len_ext    = blfifo_pkg::BYTES_W'(packet_length);
  assign head_ext   = blfifo_pkg::BYTES_W'(head_length);
  assign single_sum = {1'b0, bytes_held} + {1'b0, len_ext};
  assign single_ok  = slot_free && (single_sum < {1'b0, capacity});
  assign fits       = slot_free && (len_ext <= remaining);
  // Before the first miss any nonzero budget will do; afterwards a retry
  // needs a minimum amount of headroom left.
  assign burst_ok   = broken ? (fits && (remaining >= blfifo_pkg::MIN_RETRY_BYTES))
                             : (fits && (remaining != '0));

  always_comb begin
    admit.push       = 1'b0;
    admit.pop        = 1'b0;
    admit.accepted   = 1'b0;
    admit.broken_nxt = 1'b0;
    admit.bytes_nxt  = bytes_held;
    case (op)
      blfifo_pkg::OP_SINGLE: begin
        admit.push = single_ok;
      end
      blfifo_pkg::OP_BURST: begin
        admit.push       = burst_ok;
        admit.broken_nxt = !burst_last && (broken || !burst_ok);
      end
      blfifo_pkg::OP_DEQ: begin
        admit.pop = entry_count != '0;
      end
      default: begin
        admit.push = 1'b0;
      end
    endcase
    admit.accepted = admit.push || admit.pop;
    if (admit.push) begin
      admit.bytes_nxt = bytes_held + len_ext;
    end else if (admit.pop) begin
      admit.bytes_nxt = (bytes_held >= head_ext) ? (bytes_held - head_ext) : '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/byte_limited_packet_fifo_core.sv]
`default_nettype none
// Packet descriptor FIFO with a byte budget.
// The input channel (in_valid/in_ready) carries one item per operation:
// single enqueue, burst enqueue (one packet per item, in_burst_last on the
// final one) or dequeue. Every item produces exactly one result item on the
// out channel (out_valid/out_ready) with the accepted flag, the dequeued
// handle and length, and the byte and entry counts after the operation.
// cfg_wr_en/cfg_wr_data set the byte budget; write it only while idle.
// An accepted item is registered and then decided in the execute state once
// the output register is free; its result is then written to the output
// register. The block handles one item at a time: each item is accepted,
// then executed on the descriptor RAM's registered read, and no new item
// is taken until the execute state has finished with the last one.
// A finished result waits in the output register while the next item is
// taken; if out_ready stays low, the execute stage holds its item and
// in_ready stays low until the output register frees up.
// Reset (synchronous, rst_n low) empties the queue, clears the byte count,
// the burst state and the budget; the RAM contents are not cleared and no
// clearing pass runs, so the block is ready right after reset.
module byte_limited_packet_fifo_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [blfifo_pkg::BYTES_W-1:0]     cfg_wr_data,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [1:0]                         in_op,
  input  wire logic [blfifo_pkg::HANDLE_W-1:0]    in_packet_handle,
  input  wire logic [blfifo_pkg::LEN_W-1:0]       in_packet_length,
  input  wire logic                               in_burst_last,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic                               out_accepted,
  output      logic [blfifo_pkg::HANDLE_W-1:0]    out_handle,
  output      logic [blfifo_pkg::LEN_W-1:0]       out_length,
  output      logic [blfifo_pkg::BYTES_W-1:0]     out_bytes_in_use,
  output      logic [blfifo_pkg::CNT_W-1:0]       out_entries_in_use
);

  blfifo_pkg::state_t state_r, state_nxt;

  logic [blfifo_pkg::BYTES_W-1:0]  capacity_r;
  logic [blfifo_pkg::PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [blfifo_pkg::PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [blfifo_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [blfifo_pkg::BYTES_W-1:0]  bytes_r;
  logic                            broken_r;

  logic [1:0]                      op_r;
  logic [blfifo_pkg::HANDLE_W-1:0] handle_r;
  logic [blfifo_pkg::LEN_W-1:0]    length_r;
  logic                            last_r;
  logic [blfifo_pkg::BYTES_W-1:0]  remaining_r, remaining_nxt;

  logic                            out_valid_r;
  logic                            out_acc_r;
  logic [blfifo_pkg::HANDLE_W-1:0] out_handle_r;
  logic [blfifo_pkg::LEN_W-1:0]    out_length_r;
  logic [blfifo_pkg::BYTES_W-1:0]  out_bytes_r;
  logic [blfifo_pkg::CNT_W-1:0]    out_count_r;

  logic                            in_fire;
  logic                            exec_go;
  logic [blfifo_pkg::ENTRY_W-1:0]  ram_rd_data;
  logic [blfifo_pkg::ENTRY_W-1:0]  ram_wr_data;
  logic [blfifo_pkg::HANDLE_W-1:0] head_handle;
  logic [blfifo_pkg::LEN_W-1:0]    head_length;
  blfifo_pkg::admit_t              admit;

  assign in_ready = state_r == blfifo_pkg::ST_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign exec_go  = (state_r == blfifo_pkg::ST_EXEC) && (!out_valid_r || out_ready);

  // Headroom is taken at acceptance so the execute cycle only compares.
  assign remaining_nxt = (capacity_r > bytes_r) ? (capacity_r - bytes_r) : '0;

  assign ram_wr_data = {handle_r, length_r};
  assign head_handle = ram_rd_data[blfifo_pkg::ENTRY_W-1:blfifo_pkg::LEN_W];
  assign head_length = ram_rd_data[blfifo_pkg::LEN_W-1:0];

  // The head entry is read at acceptance; any earlier push has already been
  // written, since only one item is in flight.
  blfifo_ram #(
    .DATA_W (blfifo_pkg::ENTRY_W),
    .DEPTH  (blfifo_pkg::RING_DEPTH)
  ) u_desc_ram (
    .clk     (clk),
    .wr_en   (exec_go && admit.push),
    .wr_addr (wr_ptr_r),
    .wr_data (ram_wr_data),
    .rd_en   (in_fire),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rd_data)
  );

  blfifo_admit u_admit (
    .op            (op_r),
    .packet_length (length_r),
    .burst_last    (last_r),
    .capacity      (capacity_r),
    .bytes_held    (bytes_r),
    .remaining     (remaining_r),
    .entry_count   (count_r),
    .broken        (broken_r),
    .head_length   (head_length),
    .admit         (admit)
  );

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (admit.push) begin
      wr_ptr_nxt = (wr_ptr_r == blfifo_pkg::PTR_W'(blfifo_pkg::RING_DEPTH - 1)) ? '0
                                                                              : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end else if (admit.pop) begin
      rd_ptr_nxt = (rd_ptr_r == blfifo_pkg::PTR_W'(blfifo_pkg::RING_DEPTH - 1)) ? '0
                                                                              : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blfifo_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = blfifo_pkg::ST_EXEC;
        end
      end
      blfifo_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt = blfifo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = blfifo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blfifo_pkg::ST_IDLE;
      capacity_r  <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      bytes_r     <= '0;
      broken_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      if (exec_go) begin
        rd_ptr_r    <= rd_ptr_nxt;
        wr_ptr_r    <= wr_ptr_nxt;
        count_r     <= count_nxt;
        bytes_r     <= admit.bytes_nxt;
        broken_r    <= admit.broken_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= in_op;
      handle_r    <= in_packet_handle;
      length_r    <= in_packet_length;
      last_r      <= in_burst_last;
      remaining_r <= remaining_nxt;
    end
    if (exec_go) begin
      out_acc_r    <= admit.accepted;
      out_handle_r <= admit.pop ? head_handle : '0;
      out_length_r <= admit.pop ? head_length : '0;
      out_bytes_r  <= admit.bytes_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_handle         = out_handle_r;
  assign out_length         = out_length_r;
  assign out_bytes_in_use   = out_bytes_r;
  assign out_entries_in_use = out_count_r;

endmodule

`default_nettype wire
